// ===== hdl/jsu_pkg.sv =====
// Shared constants, types and helpers for the JSON string unescaper.
// Used by json_string_unescaper and its port checker; depends on nothing.
`default_nettype none

package jsu_pkg;

   localparam int MAX_RESULTS = 6;
   localparam int CNT_W       = $clog2(MAX_RESULTS + 1);
   localparam int PEND_DEPTH  = 5;
   localparam int PEND_IDX_W  = $clog2(PEND_DEPTH);
   localparam int ERR_POS_W   = 16;

   localparam logic [7:0] CHAR_BSLASH = 8'h5C;
   localparam logic [7:0] CHAR_QUOTE  = 8'h22;
   localparam logic [7:0] CHAR_SLASH  = 8'h2F;
   localparam logic [7:0] CHAR_LO_B   = 8'h62;
   localparam logic [7:0] CHAR_LO_F   = 8'h66;
   localparam logic [7:0] CHAR_LO_N   = 8'h6E;
   localparam logic [7:0] CHAR_LO_R   = 8'h72;
   localparam logic [7:0] CHAR_LO_T   = 8'h74;
   localparam logic [7:0] CHAR_LO_U   = 8'h75;
   localparam logic [7:0] CODE_BS     = 8'h08;
   localparam logic [7:0] CODE_FF     = 8'h0C;
   localparam logic [7:0] CODE_LF     = 8'h0A;
   localparam logic [7:0] CODE_CR     = 8'h0D;
   localparam logic [7:0] CODE_TAB    = 8'h09;

   typedef struct packed {
      logic       ok;
      logic [3:0] value;
   } hex_digit_type;

   function automatic hex_digit_type hex_value(input logic [7:0] b);
      hex_digit_type r;
      r.ok    = 1'b1;
      r.value = 4'd0;
      if (b >= 8'h30 && b <= 8'h39) begin
         r.value = 4'(b - 8'h30);
      end else if (b >= 8'h61 && b <= 8'h66) begin
         r.value = 4'(b - 8'h57);
      end else if (b >= 8'h41 && b <= 8'h46) begin
         r.value = 4'(b - 8'h37);
      end else begin
         r.ok = 1'b0;
      end
      return r;
   endfunction

endpackage

`default_nettype wire

// ===== hdl/json_string_unescaper.sv =====
// JSON string body unescaper: escaped bytes in, unescaped UTF-8 bytes out.
// Depends on jsu_pkg for character codes, counts and the hex digit decoder.
//
// Usage:
//   req_ channel carries one byte of the escaped string body per beat, with
//   req_in_last on the final byte of a string. rsp_ channel carries one output
//   byte per beat, with error flag and error position, run_end on the last
//   beat caused by an input byte and text_end on the last beat of a string.
//   An input byte yields zero to six output beats. All of them are computed
//   in the cycle the byte is accepted and loaded into a six-entry result
//   buffer; the first appears on rsp_ in the cycle after acceptance.
//   Throughput: one input byte per cycle while each byte yields at most one
//   beat and every beat is taken. A byte that yields more beats keeps
//   req_ready low as the result buffer drains, one beat per cycle while
//   rsp_ready is high; req_ready rises in the cycle its last beat is taken.
//   A stalled receiver holds the current beat steady; once the buffer holds a
//   beat that is not being taken, no new input byte is accepted.
//   Reset (synchronous) empties the result buffer and returns the decoder to
//   plain text with the byte index at zero. The end of a string does the same
//   for the decoder. Error positions count from zero and saturate.
`default_nettype none

module json_string_unescaper #(
   parameter int POS_BITS = 16
) (
   input  wire logic                         clock,
   input  wire logic                         reset,
   input  wire logic                         req_valid,
   output logic                              req_ready,
   input  wire logic [7:0]                   req_in_byte,
   input  wire logic                         req_in_last,
   output logic                              rsp_valid,
   input  wire logic                         rsp_ready,
   output logic [7:0]                        rsp_out_byte,
   output logic                              rsp_err_here,
   output logic [jsu_pkg::ERR_POS_W-1:0]     rsp_err_pos,
   output logic                              rsp_run_end,
   output logic                              rsp_text_end
);

   localparam int NR    = jsu_pkg::MAX_RESULTS;
   localparam int CW    = jsu_pkg::CNT_W;
   localparam int ND    = jsu_pkg::PEND_DEPTH;
   localparam int EPW   = jsu_pkg::ERR_POS_W;
   localparam int EXT_W = (POS_BITS > EPW) ? POS_BITS : EPW;

   typedef enum logic [1:0] {
      MODE_PLAIN,
      MODE_BSLASH,
      MODE_HEX
   } mode_type;

   mode_type              mode_ff, mode_in;
   logic [1:0]            seen_ff, seen_in;
   logic [11:0]           accum_ff, accum_in;
   logic [7:0]            pend_ff [ND];
   logic [7:0]            pend_in [ND];
   logic [POS_BITS-1:0]   start_ff, start_in;
   logic [POS_BITS-1:0]   index_ff, index_in;

   logic [7:0]            buf_ff [NR];
   logic [7:0]            buf_in [NR];
   logic [NR-1:0]         mask_ff, mask_in;
   logic [CW-1:0]         cnt_ff, cnt_in;
   logic [EPW-1:0]        pos_ff, pos_in;
   logic                  last_ff, last_in;

   logic                  req_fire, rsp_fire;
   logic [7:0]            b;
   jsu_pkg::hex_digit_type hd;
   logic [CW-1:0]         held;
   logic [15:0]           code;
   logic [POS_BITS-1:0]   err_at;

   function automatic logic [POS_BITS-1:0] sat_add(input logic [POS_BITS-1:0] a,
                                                   input logic [1:0] amt);
      logic [POS_BITS:0] s;
      s = {1'b0, a} + (POS_BITS + 1)'(amt);
      return s[POS_BITS] ? {POS_BITS{1'b1}} : s[POS_BITS-1:0];
   endfunction

   function automatic logic [EPW-1:0] clip_pos(input logic [POS_BITS-1:0] p);
      logic [EXT_W-1:0] e;
      e = EXT_W'(p);
      return (e > EXT_W'({EPW{1'b1}})) ? {EPW{1'b1}} : e[EPW-1:0];
   endfunction

   assign rsp_valid    = (cnt_ff != '0);
   assign req_ready    = (cnt_ff == '0) || (cnt_ff == CW'(1) && rsp_ready);
   assign req_fire     = req_valid && req_ready;
   assign rsp_fire     = rsp_valid && rsp_ready;
   assign rsp_out_byte = buf_ff[0];
   assign rsp_err_here = mask_ff[0];
   assign rsp_err_pos  = mask_ff[0] ? pos_ff : '0;
   assign rsp_run_end  = (cnt_ff == CW'(1));
   assign rsp_text_end = (cnt_ff == CW'(1)) && last_ff;

   assign b    = req_in_byte;
   assign hd   = jsu_pkg::hex_value(req_in_byte);
   assign held = CW'(2) + CW'(seen_ff);
   assign code = {accum_ff, hd.value};

   always_comb begin
      mode_in  = mode_ff;
      seen_in  = seen_ff;
      accum_in = accum_ff;
      pend_in  = pend_ff;
      start_in = start_ff;
      index_in = index_ff;
      buf_in   = buf_ff;
      mask_in  = mask_ff;
      cnt_in   = cnt_ff;
      pos_in   = pos_ff;
      last_in  = last_ff;
      err_at   = index_ff;

      if (req_fire) begin
         mode_in = MODE_PLAIN;
         mask_in = '0;
         cnt_in  = '0;
         last_in = req_in_last;
         for (int k = 0; k < NR; k++) begin
            buf_in[k] = b;
         end

         unique case (mode_ff)
            MODE_BSLASH: begin
               cnt_in = CW'(1);
               priority case (b)
                  jsu_pkg::CHAR_QUOTE:  buf_in[0] = jsu_pkg::CHAR_QUOTE;
                  jsu_pkg::CHAR_BSLASH: buf_in[0] = jsu_pkg::CHAR_BSLASH;
                  jsu_pkg::CHAR_SLASH:  buf_in[0] = jsu_pkg::CHAR_SLASH;
                  jsu_pkg::CHAR_LO_B:   buf_in[0] = jsu_pkg::CODE_BS;
                  jsu_pkg::CHAR_LO_F:   buf_in[0] = jsu_pkg::CODE_FF;
                  jsu_pkg::CHAR_LO_N:   buf_in[0] = jsu_pkg::CODE_LF;
                  jsu_pkg::CHAR_LO_R:   buf_in[0] = jsu_pkg::CODE_CR;
                  jsu_pkg::CHAR_LO_T:   buf_in[0] = jsu_pkg::CODE_TAB;
                  jsu_pkg::CHAR_LO_U: begin
                     pend_in[1] = b;
                     if (req_in_last) begin
                        // truncated escape: backslash and u pass verbatim
                        cnt_in     = CW'(2);
                        buf_in[0]  = jsu_pkg::CHAR_BSLASH;
                        mask_in[0] = 1'b1;
                        err_at     = start_ff;
                     end else begin
                        cnt_in   = '0;
                        seen_in  = '0;
                        accum_in = '0;
                        mode_in  = MODE_HEX;
                     end
                  end
                  default: begin
                     cnt_in     = CW'(2);
                     buf_in[0]  = jsu_pkg::CHAR_BSLASH;
                     mask_in[0] = 1'b1;
                     err_at     = sat_add(start_ff, 2'd1);
                  end
               endcase
            end
            MODE_HEX: begin
               // error paths: held escape bytes, then the current byte
               for (int k = 0; k < ND; k++) begin
                  if (CW'(k) < held) begin
                     buf_in[k] = pend_ff[k];
                  end
               end
               if (!hd.ok) begin
                  mask_in[0] = 1'b1;
                  err_at     = index_ff;
                  cnt_in     = held + CW'(1);
                  if (b == jsu_pkg::CHAR_BSLASH) begin
                     if (req_in_last) begin
                        mask_in[held] = 1'b1;
                     end else begin
                        cnt_in     = held;
                        pend_in[0] = b;
                        start_in   = index_ff;
                        mode_in    = MODE_BSLASH;
                     end
                  end
               end else if (seen_ff == 2'd3) begin
                  seen_in  = '0;
                  accum_in = '0;
                  if (code[15:11] == 5'b11011) begin
                     // surrogate: all six escape bytes pass verbatim
                     cnt_in     = CW'(NR);
                     mask_in[0] = 1'b1;
                     err_at     = sat_add(start_ff, 2'd2);
                  end else if (code < 16'h0080) begin
                     cnt_in    = CW'(1);
                     buf_in[0] = code[7:0];
                  end else if (code < 16'h0800) begin
                     cnt_in    = CW'(2);
                     buf_in[0] = {3'b110, code[10:6]};
                     buf_in[1] = {2'b10, code[5:0]};
                  end else begin
                     cnt_in    = CW'(3);
                     buf_in[0] = {4'b1110, code[15:12]};
                     buf_in[1] = {2'b10, code[11:6]};
                     buf_in[2] = {2'b10, code[5:0]};
                  end
               end else if (req_in_last) begin
                  cnt_in     = held + CW'(1);
                  mask_in[0] = 1'b1;
                  err_at     = start_ff;
               end else begin
                  pend_in[held[jsu_pkg::PEND_IDX_W-1:0]] = b;
                  seen_in  = seen_ff + 2'd1;
                  accum_in = {accum_ff[7:0], hd.value};
                  mode_in  = MODE_HEX;
               end
            end
            default: begin
               if (b == jsu_pkg::CHAR_BSLASH && !req_in_last) begin
                  pend_in[0] = b;
                  start_in   = index_ff;
                  mode_in    = MODE_BSLASH;
               end else begin
                  cnt_in     = CW'(1);
                  mask_in[0] = (b == jsu_pkg::CHAR_BSLASH);
                  err_at     = index_ff;
               end
            end
         endcase

         pos_in = clip_pos(err_at);

         if (req_in_last) begin
            mode_in  = MODE_PLAIN;
            seen_in  = '0;
            accum_in = '0;
            start_in = '0;
            index_in = '0;
         end else begin
            index_in = sat_add(index_ff, 2'd1);
         end
      end else if (rsp_fire) begin
         // advance the result buffer by one beat
         for (int k = 0; k < NR - 1; k++) begin
            buf_in[k] = buf_ff[k + 1];
         end
         mask_in = mask_ff >> 1;
         cnt_in  = cnt_ff - CW'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         mode_ff  <= MODE_PLAIN;
         seen_ff  <= '0;
         accum_ff <= '0;
         start_ff <= '0;
         index_ff <= '0;
         cnt_ff   <= '0;
         mask_ff  <= '0;
         last_ff  <= 1'b0;
      end else begin
         mode_ff  <= mode_in;
         seen_ff  <= seen_in;
         accum_ff <= accum_in;
         start_ff <= start_in;
         index_ff <= index_in;
         cnt_ff   <= cnt_in;
         mask_ff  <= mask_in;
         last_ff  <= last_in;
      end
      pend_ff <= pend_in;
      buf_ff  <= buf_in;
      pos_ff  <= pos_in;
   end

endmodule

`default_nettype wire

// ===== hdl/jsu_checker.sv =====
// Port-level checker for json_string_unescaper, attached by the bind below.
// Depends on jsu_pkg for the error position width.
`default_nettype none

module jsu_checker (
   input wire logic                          clock,
   input wire logic                          reset,
   input wire logic                          req_ready,
   input wire logic                          rsp_valid,
   input wire logic                          rsp_ready,
   input wire logic [7:0]                    rsp_out_byte,
   input wire logic                          rsp_err_here,
   input wire logic [jsu_pkg::ERR_POS_W-1:0] rsp_err_pos,
   input wire logic                          rsp_run_end,
   input wire logic                          rsp_text_end
);

   // hold a stalled beat
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_out_byte)
         && $stable(rsp_err_here) && $stable(rsp_err_pos)
         && $stable(rsp_run_end) && $stable(rsp_text_end))
      else $error("stalled result beat changed");

   a_text_end_run: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_text_end |-> rsp_run_end)
      else $error("text_end without run_end");

   a_stall_blocks_input: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |-> !req_ready)
      else $error("input taken while a result beat is stalled");

   a_run_end_frees_input: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_ready && rsp_run_end |-> req_ready)
      else $error("input not ready as the last pending beat leaves");

   a_reset_empty: assert property (@(posedge clock)
      reset |=> !rsp_valid)
      else $error("result valid right after reset");

endmodule

bind json_string_unescaper jsu_checker u_jsu_checker (.*);

`default_nettype wire
